// ----- rtl/ssnf_pkg.sv -----
// shared types, constants and the glyph table of the seven-segment formatter
// no dependencies; every other file of the block depends on this package
package ssnf_pkg;

    typedef enum logic [1:0] {
        ACT_DEC   = 2'd0,
        ACT_HEX   = 2'd1,
        ACT_CLOCK = 2'd2,
        ACT_COLON = 2'd3
    } action_t;

    localparam int DEC_W = 14;
    localparam logic [DEC_W-1:0] DEC_MAX = 14'd9999;

    // reciprocal constants for division by 1000, 100 and 10, exact below 10000
    localparam logic [DEC_W-1:0] RCP_1000 = 14'd8389;
    localparam int SH_1000 = 23;
    localparam logic [DEC_W-1:0] RCP_100 = 14'd5243;
    localparam int SH_100 = 19;
    localparam logic [DEC_W-1:0] RCP_10 = 14'd6554;
    localparam int SH_10 = 16;

    localparam logic [6:0] GLYPH_BLANK = 7'h00;

    typedef struct packed {
        action_t    action;
        logic [15:0] value;
        logic [7:0] char_first;
        logic [7:0] char_second;
        logic [7:0] char_third;
        logic [7:0] char_fourth;
        logic       time_fix;
        logic [2:0] colon_bits;
    } req_t;

    typedef struct packed {
        logic [6:0] seg_pos_one;
        logic [6:0] seg_pos_two;
        logic [6:0] seg_pos_three;
        logic [6:0] seg_pos_four;
        logic [3:0] colon_word;
        logic       digits_valid;
        logic       colon_valid;
    } res_t;

    typedef struct packed {
        logic [3:0] d0;
        logic [3:0] d1;
        logic [3:0] d2;
        logic [3:0] d3;
    } digits_t;

    // segment a in bit 0 through segment g in bit 6
    function automatic logic [6:0] glyph_of(input logic [3:0] code);
        logic [6:0] g;
        begin
            case (code)
                4'h0:    g = 7'h3F;
                4'h1:    g = 7'h06;
                4'h2:    g = 7'h5B;
                4'h3:    g = 7'h4F;
                4'h4:    g = 7'h66;
                4'h5:    g = 7'h6D;
                4'h6:    g = 7'h7D;
                4'h7:    g = 7'h07;
                4'h8:    g = 7'h7F;
                4'h9:    g = 7'h6F;
                4'hA:    g = 7'h77;
                4'hB:    g = 7'h7C;
                4'hC:    g = 7'h39;
                4'hD:    g = 7'h5E;
                4'hE:    g = 7'h79;
                4'hF:    g = 7'h71;
                default: g = GLYPH_BLANK;
            endcase
            return g;
        end
    endfunction

endpackage

// ----- rtl/ssnf_if.sv -----
// valid/ready channel interfaces for requests and results
// depends on ssnf_pkg for the payload structs
interface ssnf_req_if;
    ssnf_pkg::req_t data;
    logic           valid;
    logic           ready;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ssnf_res_if;
    ssnf_pkg::res_t data;
    logic           valid;
    logic           ready;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/seven_segment_number_formatter.sv -----
// seven-segment number formatter: request register, formatting logic, result register
// an accepted request passes the request register, then the result register
// throughput: one request per cycle while res.ready holds; the result register frees the input side
// while a result waits, so a stalled sink costs at most the two stored items
// reset: asynchronous active-low rst_n empties both stages; no payload is cleared
module seven_segment_number_formatter (
    input logic        clk,
    input logic        rst_n,
    ssnf_req_if.sink   req,
    ssnf_res_if.source res
);
    import ssnf_pkg::*;

    logic in_vld_reg;
    logic in_vld_next;
    req_t in_data_reg;
    logic out_vld_reg;
    logic out_vld_next;
    res_t out_data_reg;
    res_t fmt_data;
    logic out_adv;
    logic in_take;

    assign out_adv = !out_vld_reg || res.ready;
    assign req.ready = !in_vld_reg || out_adv;
    assign in_take = req.valid && req.ready;

    ssnf_fmt u_fmt (
        .req_data (in_data_reg),
        .res_data (fmt_data)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (out_adv)
        begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_adv ? in_vld_reg : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= req.data;
        end
        if (out_adv && in_vld_reg)
        begin
            out_data_reg <= fmt_data;
        end
    end

    assign res.valid = out_vld_reg;
    assign res.data  = out_data_reg;

endmodule

// ----- rtl/ssnf_dec_split.sv -----
// splits a binary value into four decimal digits, saturating at 9999
// depends on ssnf_pkg; pure combinational logic, reciprocal multiplies in parallel
module ssnf_dec_split (
    input  logic [15:0]      value,
    output ssnf_pkg::digits_t digits
);
    import ssnf_pkg::*;

    logic [DEC_W-1:0]   v;
    logic [2*DEC_W-1:0] p1000;
    logic [2*DEC_W-1:0] p100;
    logic [2*DEC_W-1:0] p10;
    logic [3:0]         q1000;
    logic [6:0]         q100;
    logic [9:0]         q10;
    logic [6:0]         r1;
    logic [9:0]         r2;
    logic [DEC_W-1:0]   r3;

    assign v = (value > {2'b00, DEC_MAX}) ? DEC_MAX : value[DEC_W-1:0];

    // three independent quotients, each one constant multiply
    assign p1000 = {{DEC_W{1'b0}}, v} * {{DEC_W{1'b0}}, RCP_1000};
    assign p100  = {{DEC_W{1'b0}}, v} * {{DEC_W{1'b0}}, RCP_100};
    assign p10   = {{DEC_W{1'b0}}, v} * {{DEC_W{1'b0}}, RCP_10};

    assign q1000 = p1000[SH_1000 +: 4];
    assign q100  = p100[SH_100 +: 7];
    assign q10   = p10[SH_10 +: 10];

    // each digit below the thousands is a quotient minus ten times the next coarser one
    assign r1 = q100 - {q1000, 3'b000} - {2'b00, q1000, 1'b0};
    assign r2 = q10 - {q100, 3'b000} - {2'b00, q100, 1'b0};
    assign r3 = v - {1'b0, q10, 3'b000} - {3'b000, q10, 1'b0};

    assign digits.d0 = q1000;
    assign digits.d1 = r1[3:0];
    assign digits.d2 = r2[3:0];
    assign digits.d3 = r3[3:0];

endmodule

// ----- rtl/ssnf_fmt.sv -----
// picks digits by action, maps them to glyphs and packs the colon row
// depends on ssnf_pkg and ssnf_dec_split
module ssnf_fmt (
    input  ssnf_pkg::req_t req_data,
    output ssnf_pkg::res_t res_data
);
    import ssnf_pkg::*;

    digits_t dec_digits;
    digits_t sel;
    logic    blank_first;
    logic    noon_fix;

    ssnf_dec_split u_dec_split (
        .value  (req_data.value),
        .digits (dec_digits)
    );

    // in clock mode, a leading 00 becomes 12 when the time flag is set
    assign noon_fix = req_data.time_fix && (req_data.char_first[3:0] == 4'h0)
                      && (req_data.char_second[3:0] == 4'h0);

    always_comb
    begin
        sel         = dec_digits;
        blank_first = 1'b0;
        case (req_data.action)
            ACT_DEC:
            begin
                sel = dec_digits;
            end
            ACT_HEX:
            begin
                sel = req_data.value;
            end
            ACT_CLOCK:
            begin
                sel.d0 = req_data.char_first[3:0];
                sel.d1 = req_data.char_second[3:0];
                sel.d2 = req_data.char_third[3:0];
                sel.d3 = req_data.char_fourth[3:0];
                if (noon_fix)
                begin
                    sel.d0 = 4'd1;
                    sel.d1 = 4'd2;
                end
                else if (req_data.char_first[3:0] == 4'h0)
                begin
                    blank_first = 1'b1;
                end
            end
            default:
            begin
                sel = dec_digits;
            end
        endcase
    end

    always_comb
    begin
        res_data = '0;
        if (req_data.action == ACT_COLON)
        begin
            res_data.colon_word  = {req_data.colon_bits[0], req_data.colon_bits[1],
                                    req_data.colon_bits[2], 1'b0};
            res_data.colon_valid = 1'b1;
        end
        else
        begin
            res_data.seg_pos_one   = blank_first ? GLYPH_BLANK : glyph_of(sel.d0);
            res_data.seg_pos_two   = glyph_of(sel.d1);
            res_data.seg_pos_three = glyph_of(sel.d2);
            res_data.seg_pos_four  = glyph_of(sel.d3);
            res_data.digits_valid  = 1'b1;
        end
    end

endmodule

// ----- rtl/ssnf_checker.sv -----
// port-level checks on the result channel of the formatter, bound to the top level
// depends on ssnf_pkg and seven_segment_number_formatter
module ssnf_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           res_valid,
    input logic           res_ready,
    input ssnf_pkg::res_t res_data
);
    import ssnf_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // every result writes exactly one of the two row groups
    a_one_group: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.digits_valid != res_data.colon_valid))
        else $error("result marks both or neither row group");

    // a colon result leaves all digit rows dark and the low colon bit clear
    a_colon_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.colon_valid |->
            (res_data.seg_pos_one == 7'h00) && (res_data.seg_pos_two == 7'h00)
            && (res_data.seg_pos_three == 7'h00) && (res_data.seg_pos_four == 7'h00)
            && !res_data.colon_word[0])
        else $error("colon result carries digit data");

    // a digit result carries an empty colon row and a lit second digit
    a_digits_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.digits_valid |->
            (res_data.colon_word == 4'h0) && (res_data.seg_pos_two != 7'h00))
        else $error("digit result carries colon data or a dark digit");

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
